[design/uri3_pkg.sv]
`default_nettype none

package uri3_pkg;

  // Register indexes on the configuration port.
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMPARE_MODE = 1'd1;

  localparam int CFG_DATA_BITS   = 13;
  localparam int LINE_WIDTH_BITS = 13;
  localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RESET = 13'd640;
  localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_MIN   = 13'd3;

  localparam int POS_BITS = 12;
  localparam logic [POS_BITS-1:0] ROW_MAX = 12'd4095;

  typedef logic [3:0] label_t;
  localparam label_t NONUNIFORM_LABEL = 4'd9;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    label_t              label;
    logic [POS_BITS-1:0] center_col;
    logic [POS_BITS-1:0] center_row;
  } out_word_t;

  // Rotation-invariant uniform label of a circular 8-bit pattern: the number
  // of set bits when there are at most two 0/1 transitions, otherwise the
  // non-uniform code.
  function automatic label_t ri_label(input logic [7:0] k);
    logic [7:0] rot;
    logic [7:0] diff;
    logic [3:0] ones;
    logic [3:0] trans;
    rot   = {k[6:0], k[7]};
    diff  = k ^ rot;
    ones  = '0;
    trans = '0;
    for (int i = 0; i < 8; i++) begin
      ones  = ones + {3'd0, k[i]};
      trans = trans + {3'd0, diff[i]};
    end
    return (trans <= 4'd2) ? ones : NONUNIFORM_LABEL;
  endfunction

endpackage

`default_nettype wire

[design/uri3_line_store.sv]
`default_nettype none

// Two line memories sharing one address space. A read is registered; a
// write to the address being read in the same cycle is forwarded.
module uri3_line_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_older,
  output logic      [DW-1:0] rd_newer,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_older,
  input  wire logic [DW-1:0] wr_newer
);

  logic [DW-1:0] older_mem [DEPTH];
  logic [DW-1:0] newer_mem [DEPTH];
  logic [DW-1:0] older_q_r, newer_q_r;
  logic [DW-1:0] older_fwd_r, newer_fwd_r;
  logic          fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= wr_older;
      newer_mem[wr_addr] <= wr_newer;
    end
    if (rd_en) begin
      older_q_r   <= older_mem[rd_addr];
      newer_q_r   <= newer_mem[rd_addr];
      older_fwd_r <= wr_older;
      newer_fwd_r <= wr_newer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_older = fwd_r ? older_fwd_r : older_q_r;
  assign rd_newer = fwd_r ? newer_fwd_r : newer_q_r;

endmodule

`default_nettype wire

[design/lbp_uniform_rotinv_3x3_unit.sv]
`default_nettype none

// Channel  Direction  Handshake            Word
// in       input      in_valid/in_ready    pixel, frame_start
// out      output     out_valid/out_ready  label, center_col, center_row
// cfg      input      cfg_we               cfg_index, cfg_data
//
// One pixel word is taken every clock cycle while the output is not stalled;
// the line memories are read at the accepting edge as the word enters the
// second stage, and the label is formed from that data and registered as it leaves.
// Reset clears the position counters, the window and the pipeline valid bits;
// the line memories are not cleared and need no clearing pass.
// A stalled output holds its word while the next word moves up behind it.
module lbp_uniform_rotinv_3x3_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire uri3_pkg::in_word_t                      in_data,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output uri3_pkg::out_word_t                          out_data,
  input  wire logic                                    cfg_we,
  input  wire logic [uri3_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [uri3_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  import uri3_pkg::*;

  // Address width of the line memories, and the width used to clamp the
  // configured row length against the memory depth.
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = (AW + 1 > LINE_WIDTH_BITS) ? AW + 1 : LINE_WIDTH_BITS;
  // Stored pixel width: the input word carries eight bits, masked down.
  localparam int SW = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;

  // Configuration registers.
  logic [LINE_WIDTH_BITS-1:0] line_width_r;
  logic                       compare_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RESET;
      compare_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH: begin
          line_width_r <= cfg_data[LINE_WIDTH_BITS-1:0];
        end
        REG_COMPARE_MODE: begin
          compare_mode_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Last column of a row, with the row length clamped to 3..MAX_WIDTH.
  logic [EW-1:0] lw_ext;
  logic [EW-1:0] last_full;
  logic [AW-1:0] last_col;

  always_comb begin
    lw_ext = EW'(line_width_r);
    if (lw_ext < EW'(LINE_WIDTH_MIN)) begin
      last_full = EW'(LINE_WIDTH_MIN) - EW'(1);
    end else if (lw_ext > EW'(MAX_WIDTH)) begin
      last_full = EW'(MAX_WIDTH) - EW'(1);
    end else begin
      last_full = lw_ext - EW'(1);
    end
    last_col = last_full[AW-1:0];
  end

  // Handshake and pipeline control.
  logic in_acc;
  logic s1_adv;
  logic out_free;
  logic s1_valid_r;
  logic s1_emit_r;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_emit_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Accept stage: the position of the incoming pixel. A frame start puts the
  // pixel at row 0, column 0 before anything else happens.
  logic [AW-1:0]       col_r, col_nxt;
  logic [POS_BITS-1:0] row_r, row_nxt;
  logic [AW-1:0]       cur_col;
  logic [POS_BITS-1:0] cur_row;
  logic                cur_emit;

  always_comb begin
    cur_col  = in_data.frame_start ? '0 : col_r;
    cur_row  = in_data.frame_start ? '0 : row_r;
    cur_emit = (cur_row >= POS_BITS'(2)) && (cur_col >= AW'(2));
    if (cur_col >= last_col) begin
      col_nxt = '0;
      row_nxt = (cur_row < ROW_MAX) ? cur_row + POS_BITS'(1) : cur_row;
    end else begin
      col_nxt = cur_col + AW'(1);
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Second stage: the word waits here while the line memories are read.
  logic [AW-1:0]       s1_col_r;
  logic [POS_BITS-1:0] s1_row_r;
  logic [SW-1:0]       s1_px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_acc;
      s1_emit_r  <= in_acc && cur_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r <= cur_col;
      s1_row_r <= cur_row;
      s1_px_r  <= in_data.pixel[SW-1:0];
    end
  end

  // The pixels above the incoming one, in the centre row and the row above,
  // come from the line memories; when the second stage moves on, the middle
  // line shifts into the older one and the new pixel goes into the newer one.
  logic [SW-1:0] top_px;
  logic [SW-1:0] mid_px;

  uri3_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (SW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (cur_col),
    .rd_older (top_px),
    .rd_newer (mid_px),
    .wr_en    (s1_adv),
    .wr_addr  (s1_col_r),
    .wr_older (mid_px),
    .wr_newer (s1_px_r)
  );

  // Window of the two previous columns: entries 0..2 hold column c-2 (top,
  // middle, bottom), entries 3..5 hold column c-1; entry 4 is the centre.
  logic [SW-1:0] win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_px;
      win_r[4] <= mid_px;
      win_r[5] <= s1_px_r;
    end
  end

  // Circular pattern around the centre, starting at the top-left neighbour
  // and running clockwise down to the left neighbour in bit 0.
  logic [SW-1:0] nb [8];
  logic [7:0]    pattern;

  always_comb begin
    nb[7] = win_r[0];
    nb[6] = win_r[3];
    nb[5] = top_px;
    nb[4] = mid_px;
    nb[3] = s1_px_r;
    nb[2] = win_r[5];
    nb[1] = win_r[2];
    nb[0] = win_r[1];
    for (int i = 0; i < 8; i++) begin
      pattern[i] = compare_mode_r ? (nb[i] > win_r[4]) : (nb[i] >= win_r[4]);
    end
  end

  // Output register: the centre sits one column and one row behind the
  // incoming pixel.
  logic [AW-1:0]       col_m1;
  logic [POS_BITS-1:0] row_m1;
  out_word_t           out_r;
  logic                out_valid_r;

  assign col_m1 = s1_col_r - AW'(1);
  assign row_m1 = s1_row_r - POS_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_r.label      <= ri_label(pattern);
      out_r.center_col <= POS_BITS'(col_m1);
      out_r.center_row <= row_m1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[tb/sv/tb_lbp_uniform_rotinv_3x3_unit.sv]
`default_nettype none

module tb_lbp_uniform_rotinv_3x3_unit;
  import uri3_pkg::*;

  localparam int MAX_COLS      = 4096;
  // The settling pause is a comfortable margin for the unit's pipeline to drain.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 400;

  // How the pixel values of a frame are drawn.
  typedef enum int {PIX_NOISE, PIX_NEAR, PIX_EXTREME, PIX_FLAT} pix_style_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  in_word_t                  in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_word_t                 out_data;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  lbp_uniform_rotinv_3x3_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Our own copy of the register settings, updated as each write is issued.
  logic [LINE_WIDTH_BITS-1:0] width_reg      = LINE_WIDTH_RESET;
  logic                       compare_strict = 1'b0;

  // Predicted state of the neighbourhood: two previous rows, the two previous
  // columns of the window (top, middle, bottom each) and the incoming position.
  logic [7:0]  older_rows [MAX_COLS];
  logic [7:0]  newer_rows [MAX_COLS];
  logic [7:0]  win [6];
  int unsigned col_pos;
  int unsigned row_pos;

  // Pixel words waiting to be offered, and labels waiting to come out.
  in_word_t  pixel_queue [$];
  out_word_t label_queue [$];

  int unsigned items_pushed = 0;
  int unsigned items_taken  = 0;
  int unsigned stall_cycles = 0;
  int unsigned error_count  = 0;
  logic        in_took      = 1'b0;

  // Idling control: a burst starts on one try in idle_odds on average, none when calm.
  int unsigned idle_odds  = 0;
  logic        calm       = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned ready_gap  = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen  = 0;

  function automatic logic nb_bit(input logic [7:0] nb, input logic [7:0] ctr);
    return compare_strict ? (nb > ctr) : (nb >= ctr);
  endfunction

  // A circular pattern with at most two changes between neighbouring bits is
  // uniform and is labelled by its ones count; anything else is non-uniform.
  function automatic label_t ring_label(input logic [7:0] ring);
    int ones;
    int flips;
    ones  = 0;
    flips = 0;
    for (int i = 0; i < 8; i++) begin
      ones += ring[i];
      if (ring[i] != ring[(i + 1) % 8]) flips++;
    end
    return (flips <= 2) ? label_t'(ones) : NONUNIFORM_LABEL;
  endfunction

  // Moves the predicted window on by one accepted pixel word and queues the
  // label that it yields, if the centre is an interior pixel.
  function automatic void advance_window(input in_word_t w);
    int unsigned span;
    int unsigned c;
    logic [7:0]  top;
    logic [7:0]  mid;
    logic [7:0]  bot;
    logic [7:0]  ctr;
    logic [7:0]  ring;
    out_word_t   res;
    // Widths outside the usable range are clamped.
    span = width_reg;
    if (span < 3) span = 3;
    if (span > MAX_COLS) span = MAX_COLS;
    if (w.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    c   = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
    top = older_rows[c];
    mid = newer_rows[c];
    bot = w.pixel;
    if (row_pos >= 2 && col_pos >= 2) begin
      ctr  = win[4];
      ring = {nb_bit(win[0], ctr), nb_bit(win[3], ctr), nb_bit(top, ctr),
              nb_bit(mid, ctr), nb_bit(bot, ctr), nb_bit(win[5], ctr),
              nb_bit(win[2], ctr), nb_bit(win[1], ctr)};
      res.label      = ring_label(ring);
      res.center_col = POS_BITS'(col_pos - 1);
      res.center_row = POS_BITS'(row_pos - 1);
      label_queue.push_back(res);
    end
    older_rows[c] = mid;
    newer_rows[c] = w.pixel;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = bot;
    // The row count sticks at its top value, so the centre row stops one below.
    if (col_pos + 1 >= span) begin
      col_pos = 0;
      if (row_pos < ROW_MAX) row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  // Monitor: everything is sampled at the rising edge, before the unit's own
  // registers move. The prediction is made as each pixel word is accepted and
  // each result word is matched against the oldest label still waiting.
  always @(posedge clk) begin : monitor
    out_word_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        items_taken++;
        advance_window(in_data);
      end
      if (out_valid && out_ready) begin
        if (label_queue.size() == 0) begin
          $error("result word with none waiting: label %0d col %0d row %0d",
                 out_data.label, out_data.center_col, out_data.center_row);
          error_count++;
        end else begin
          want = label_queue.pop_front();
          if (out_data.label !== want.label) begin
            $error("label: expected %0d, actual %0d", want.label, out_data.label);
            error_count++;
          end
          if (out_data.center_col !== want.center_col) begin
            $error("center_col: expected %0d, actual %0d",
                   want.center_col, out_data.center_col);
            error_count++;
          end
          if (out_data.center_row !== want.center_row) begin
            $error("center_row: expected %0d, actual %0d",
                   want.center_row, out_data.center_row);
            error_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // Sender: on the falling edge it either holds the word still on offer,
  // idles through a burst, or offers the next pending pixel word.
  always @(negedge clk) begin : sender
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
        send_gap <= $urandom_range(16, 0);
        in_valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        in_data  <= pixel_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: idles in bursts, and on request holds off for a long stretch so
  // that the unit fills up and stops taking pixels.
  always @(negedge clk) begin : receiver
    if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (ready_gap != 0) begin
      ready_gap <= ready_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
      ready_gap <= $urandom_range(16, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Ends the run if nothing has moved on either channel for far too long.
  initial begin : watchdog
    do @(negedge clk);
    while (stall_cycles < STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic void send_word(input logic [7:0] px, input logic fs);
    in_word_t w;
    w.pixel       = px;
    w.frame_start = fs;
    pixel_queue.push_back(w);
    items_pushed++;
  endfunction

  function automatic logic [7:0] make_pixel(input pix_style_t style, input int base);
    int v;
    case (style)
      PIX_NEAR: begin
        v = base + $urandom_range(2, 0);
        v = v - 1;
      end
      PIX_EXTREME: v = $urandom_range(1, 0) ? 255 : 0;
      PIX_FLAT:    v = ($urandom_range(15, 0) == 0) ? $urandom_range(255, 0) : base;
      default:     v = $urandom_range(255, 0);
    endcase
    return v[7:0];
  endfunction

  // Queues a run of pixel words. A fresh run opens with a frame start; a noisy
  // one now and then restarts the frame part way through a row.
  function automatic void queue_frame(input int count, input pix_style_t style,
                                      input bit noisy, input bit fresh);
    int  base;
    logic fs;
    base = $urandom_range(254, 1);
    for (int i = 0; i < count; i++) begin
      fs = (fresh && i == 0) || (noisy && $urandom_range(199, 0) == 0);
      if ($urandom_range(31, 0) == 0) base = $urandom_range(254, 1);
      send_word(make_pixel(style, base), fs);
    end
  endfunction

  // Register writes only go out while the unit is idle; the copy used for the
  // prediction is updated at the same time.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(value);
    if (idx == REG_LINE_WIDTH) begin
      width_reg = LINE_WIDTH_BITS'(value);
    end else if (idx == REG_COMPARE_MODE) begin
      compare_strict = value[0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued word has been taken and every label has come
  // out, then lets the pipeline settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (items_taken != items_pushed || label_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned random_start;
    int unsigned row_span;
    int unsigned eff_span;
    int          frames;
    int          count;
    pix_style_t  style;

    foreach (win[i]) win[i] = '0;
    foreach (older_rows[i]) older_rows[i] = '0;
    foreach (newer_rows[i]) newer_rows[i] = '0;
    col_pos = 0;
    row_pos = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a 3 by 4 checkerboard of the extreme values. The first centre
    // sees alternating neighbours (non-uniform), the second sees all of them
    // at or above it.
    idle_odds = 6;
    write_reg(REG_LINE_WIDTH, 4);
    write_reg(REG_COMPARE_MODE, 0);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        send_word(((r + c) % 2 == 0) ? 8'd255 : 8'd0, r == 0 && c == 0);
      end
    end
    wait_idle();

    // Directed: a width below the minimum, strict comparison, a frame start
    // part way through a row, and a flat frame where no neighbour is greater.
    write_reg(REG_LINE_WIDTH, 1);
    write_reg(REG_COMPARE_MODE, 1);
    send_word(8'd7, 1'b1);
    send_word(8'd9, 1'b0);
    for (int i = 0; i < 9; i++) send_word(8'd128, i == 0);
    wait_idle();

    // The receiver holds off for a long stretch while pixels keep coming, so
    // the unit backs up and stalls its input.
    write_reg(REG_LINE_WIDTH, 8);
    write_reg(REG_COMPARE_MODE, 0);
    hold_asked++;
    queue_frame(240, PIX_NOISE, 1'b0, 1'b1);
    wait_idle();

    // Width reduced part way through a row: first past the new last column,
    // so the position wraps, then short of it, so the row simply carries on.
    write_reg(REG_LINE_WIDTH, 12);
    write_reg(REG_COMPARE_MODE, 1);
    queue_frame(12 * 3 + 7, PIX_NEAR, 1'b0, 1'b1);
    wait_idle();
    write_reg(REG_LINE_WIDTH, 5);
    queue_frame(5 * 3 + 2, PIX_NEAR, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_LINE_WIDTH, 4);
    queue_frame(4 * 4, PIX_FLAT, 1'b0, 1'b0);
    wait_idle();

    // Random frames. Each setting opens with a frame start, so a wider row
    // never reads line memory that this frame has not written.
    random_start = items_pushed;
    while (items_pushed - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(9, 0))
        0:       row_span = $urandom_range(2, 0);
        1:       row_span = $urandom_range(64, 17);
        default: row_span = $urandom_range(12, 3);
      endcase
      eff_span = (row_span < 3) ? 3 : row_span;
      write_reg(REG_LINE_WIDTH, row_span);
      write_reg(REG_COMPARE_MODE, $urandom_range(1, 0));
      case ($urandom_range(3, 0))
        0:       idle_odds = 0;
        1:       idle_odds = 3;
        2:       idle_odds = 8;
        default: idle_odds = 20;
      endcase
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames; f++) begin
        style = pix_style_t'($urandom_range(3, 0));
        count = $urandom_range(6, 3) * eff_span;
        // Now and then the frame is cut short part way through a row.
        if ($urandom_range(3, 0) == 0) count += $urandom_range(eff_span - 1, 0);
        queue_frame(count, style, $urandom_range(3, 0) == 0, 1'b1);
      end
      wait_idle();
    end

    // Widest rows: a register value above the maximum, then the maximum
    // itself; only the start of the first row is sent.
    idle_odds = 10;
    write_reg(REG_LINE_WIDTH, 8191);
    write_reg(REG_COMPARE_MODE, $urandom_range(1, 0));
    queue_frame(40, PIX_NEAR, 1'b0, 1'b1);
    wait_idle();
    write_reg(REG_LINE_WIDTH, MAX_COLS);
    queue_frame(40, PIX_NOISE, 1'b0, 1'b1);
    wait_idle();

    // A tall narrow frame.
    idle_odds = 20;
    write_reg(REG_LINE_WIDTH, 3);
    write_reg(REG_COMPARE_MODE, $urandom_range(1, 0));
    queue_frame(3 * 40, PIX_NOISE, 1'b0, 1'b1);
    wait_idle();

    // Last part: no idling on either side.
    calm = 1'b1;
    wait (send_gap == 0 && ready_gap == 0);
    write_reg(REG_LINE_WIDTH, 7);
    write_reg(REG_COMPARE_MODE, 0);
    queue_frame(7 * 12, PIX_NEAR, 1'b0, 1'b1);
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (label_queue.size() != 0) begin
      $error("%0d labels never came out", label_queue.size());
    end
    if (error_count == 0 && label_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
